// ===== hw/rtl/tlcg_pkg.sv =====
// shared constants, lane tables and controller command type for the combined lcg generator
package tlcg_pkg;

    localparam int SEED_W            = 15;
    localparam int CMD_W             = 2;
    localparam int MUL_W             = 8;
    localparam int PROD_W            = 23;
    localparam int QUO_W             = 8;
    localparam int REM_W             = 16;
    localparam int WEIGHT_W          = 18;
    localparam int RECIP_W           = 18;
    localparam int SUM_W             = 32;
    localparam int NUM_LANES         = 3;
    localparam int LANE_W            = 2;
    localparam int FRACTION_BITS_DEF = 24;
    localparam int S_TDATA_W         = ((NUM_LANES * SEED_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_LOAD_MAIN = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_ALT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DRAW_MAIN = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DRAW_ALT  = 2'd3;

    localparam logic [MUL_W-1:0] MUL_FIRST  = 8'd171;
    localparam logic [MUL_W-1:0] MUL_SECOND = 8'd172;
    localparam logic [MUL_W-1:0] MUL_THIRD  = 8'd170;

    localparam logic [SEED_W-1:0] MOD_FIRST  = 15'd30269;
    localparam logic [SEED_W-1:0] MOD_SECOND = 15'd30307;
    localparam logic [SEED_W-1:0] MOD_THIRD  = 15'd30323;

    localparam logic [WEIGHT_W-1:0] WEIGHT_FIRST  = 18'd141906;
    localparam logic [WEIGHT_W-1:0] WEIGHT_SECOND = 18'd141734;
    localparam logic [WEIGHT_W-1:0] WEIGHT_THIRD  = 18'd141648;

    // floor(2^32 / modulus), quotient estimate is exact or one low
    localparam logic [RECIP_W-1:0] RECIP_FIRST  = RECIP_W'((64'd1 << SUM_W) / 64'(MOD_FIRST));
    localparam logic [RECIP_W-1:0] RECIP_SECOND = RECIP_W'((64'd1 << SUM_W) / 64'(MOD_SECOND));
    localparam logic [RECIP_W-1:0] RECIP_THIRD  = RECIP_W'((64'd1 << SUM_W) / 64'(MOD_THIRD));

    typedef struct packed {
        logic load_main;
        logic load_alt;
        logic sel_alt;
        logic mul_en;
        logic quo_en;
        logic red_en;
        logic prod_en;
        logic sum_en;
    } tlcg_cmd_t;

    function automatic logic [MUL_W-1:0] lane_mul(input logic [LANE_W-1:0] lane);
        case (lane)
            2'd0:    lane_mul = MUL_FIRST;
            2'd1:    lane_mul = MUL_SECOND;
            default: lane_mul = MUL_THIRD;
        endcase
    endfunction

    function automatic logic [SEED_W-1:0] lane_mod(input logic [LANE_W-1:0] lane);
        case (lane)
            2'd0:    lane_mod = MOD_FIRST;
            2'd1:    lane_mod = MOD_SECOND;
            default: lane_mod = MOD_THIRD;
        endcase
    endfunction

    function automatic logic [RECIP_W-1:0] lane_recip(input logic [LANE_W-1:0] lane);
        case (lane)
            2'd0:    lane_recip = RECIP_FIRST;
            2'd1:    lane_recip = RECIP_SECOND;
            default: lane_recip = RECIP_THIRD;
        endcase
    endfunction

    function automatic logic [WEIGHT_W-1:0] lane_weight(input logic [LANE_W-1:0] lane);
        case (lane)
            2'd0:    lane_weight = WEIGHT_FIRST;
            2'd1:    lane_weight = WEIGHT_SECOND;
            default: lane_weight = WEIGHT_THIRD;
        endcase
    endfunction

endpackage

// ===== hw/rtl/tlcg_dp.sv =====
// datapath: seed banks, three-lane modular update and weighted fraction sum
module tlcg_dp import tlcg_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  tlcg_cmd_t                cmd,
    input  logic [SEED_W-1:0]        seed_a,
    input  logic [SEED_W-1:0]        seed_b,
    input  logic [SEED_W-1:0]        seed_c,
    output logic [FRACTION_BITS-1:0] fraction
);

    logic [SEED_W-1:0]        seed_in   [NUM_LANES];
    logic [SEED_W-1:0]        main_reg  [NUM_LANES];
    logic [SEED_W-1:0]        alt_reg   [NUM_LANES];
    logic [SEED_W-1:0]        seed_next [NUM_LANES];
    logic [PROD_W-1:0]        p_reg     [NUM_LANES];
    logic [QUO_W-1:0]         q_reg     [NUM_LANES];
    logic [SUM_W-1:0]         prod_reg  [NUM_LANES];
    logic [SUM_W-1:0]         sum_next;
    logic [FRACTION_BITS-1:0] fraction_reg;

    assign seed_in[0] = seed_a;
    assign seed_in[1] = seed_b;
    assign seed_in[2] = seed_c;

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        localparam logic [LANE_W-1:0] LANE = LANE_W'(i);

        logic [SEED_W-1:0]          seed_cur;
        logic [PROD_W-1:0]          p_next;
        logic [PROD_W+RECIP_W-1:0]  q_full;
        logic [PROD_W-1:0]          qm;
        logic [PROD_W-1:0]          r_full;
        logic [REM_W-1:0]           r_est;
        logic [REM_W-1:0]           r_fix;
        logic [SEED_W+WEIGHT_W-1:0] w_full;

        assign seed_cur = cmd.sel_alt ? alt_reg[i] : main_reg[i];

        // stage 1: seed times multiplier
        assign p_next = PROD_W'(seed_cur) * PROD_W'(lane_mul(LANE));

        // stage 2: quotient estimate by reciprocal
        assign q_full = (PROD_W + RECIP_W)'(p_reg[i])
                      * (PROD_W + RECIP_W)'(lane_recip(LANE));

        // stage 3: remainder with one correction step
        assign qm     = PROD_W'(q_reg[i]) * PROD_W'(lane_mod(LANE));
        assign r_full = p_reg[i] - qm;
        assign r_est  = r_full[REM_W-1:0];
        assign r_fix  = (r_est >= REM_W'(lane_mod(LANE))) ? r_est - REM_W'(lane_mod(LANE))
                                                          : r_est;
        assign seed_next[i] = r_fix[SEED_W-1:0];

        assign w_full = (SEED_W + WEIGHT_W)'(seed_cur) * (SEED_W + WEIGHT_W)'(lane_weight(LANE));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                main_reg[i] <= '0;
                alt_reg[i]  <= '0;
            end else begin
                if (cmd.load_main) begin
                    main_reg[i] <= seed_in[i];
                end else if (cmd.red_en && !cmd.sel_alt) begin
                    main_reg[i] <= seed_next[i];
                end
                if (cmd.load_alt) begin
                    alt_reg[i] <= seed_in[i];
                end else if (cmd.red_en && cmd.sel_alt) begin
                    alt_reg[i] <= seed_next[i];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (cmd.mul_en) begin
                p_reg[i] <= p_next;
            end
            if (cmd.quo_en) begin
                q_reg[i] <= q_full[SUM_W +: QUO_W];
            end
            if (cmd.prod_en) begin
                prod_reg[i] <= w_full[SUM_W-1:0];
            end
        end
    end

    // sum wraps at 32 bits, only the fraction is kept
    assign sum_next = prod_reg[0] + prod_reg[1] + prod_reg[2];

    always_ff @(posedge aclk) begin
        if (cmd.sum_en) begin
            fraction_reg <= sum_next[SUM_W-1 -: FRACTION_BITS];
        end
    end

    assign fraction = fraction_reg;

endmodule

// ===== hw/rtl/tlcg_ctrl.sv =====
// controller: command decode, update sequencing and output register handshake
module tlcg_ctrl import tlcg_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [CMD_W-1:0] s_cmd,
    output logic             m_tvalid,
    input  logic             m_tready,
    output tlcg_cmd_t        cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_QUO  = 3'd2;
    localparam logic [2:0] ST_RED  = 3'd3;
    localparam logic [2:0] ST_PROD = 3'd4;
    localparam logic [2:0] ST_SUM  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       again_reg, again_next;
    logic       sel_reg, sel_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next    = state_reg;
        again_next    = again_reg;
        sel_next      = sel_reg;
        cmd           = '0;
        cmd.sel_alt   = sel_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_cmd)
                        CMD_LOAD_MAIN: begin
                            cmd.load_main = 1'b1;
                        end
                        CMD_LOAD_ALT: begin
                            cmd.load_alt = 1'b1;
                        end
                        CMD_DRAW_MAIN: begin
                            sel_next   = 1'b0;
                            again_next = 1'b1;
                            state_next = ST_MUL;
                        end
                        CMD_DRAW_ALT: begin
                            sel_next   = 1'b1;
                            again_next = 1'b0;
                            state_next = ST_MUL;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = ST_QUO;
            end
            ST_QUO: begin
                cmd.quo_en = 1'b1;
                state_next = ST_RED;
            end
            ST_RED: begin
                cmd.red_en = 1'b1;
                if (again_reg) begin
                    again_next = 1'b0;
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_PROD;
                end
            end
            ST_PROD: begin
                cmd.prod_en = 1'b1;
                state_next  = ST_SUM;
            end
            ST_SUM: begin
                if (out_free) begin
                    cmd.sum_en = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.sum_en) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            again_reg     <= 1'b0;
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            again_reg     <= again_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hw/rtl/three_lcg_combined_random_top.sv =====
// top level of the two-bank combined lcg random source
// Two independent generators, main and seeded, each with three 15-bit seeds advanced as
// 171 mod 30269, 172 mod 30307 and 170 mod 30323. A load item (cmd 0 main, cmd 1 seeded)
// gives no result. A draw returns the weighted seed sum's fraction as unsigned
// Q0.FRACTION_BITS: a seeded draw advances its seeds once before reaching the result
// register, a main draw advances them twice. The input opens again when the result is
// written to the output register. Each seed update steps all three lanes together through
// the multiply, reciprocal-quotient and reduce steps, each lane with its own arithmetic;
// the updates are followed by the weighted product and sum steps. A draw whose result
// finds the output register still occupied waits in its last cycle until that result is
// taken. A new item is accepted as soon as a result sits in the output register, even if
// not yet taken.
module three_lcg_combined_random_top import tlcg_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [S_TDATA_W-1:0]                   s_tdata,  // seed_a, seed_b, seed_c
    input  logic [CMD_W-1:0]                       s_tuser,  // cmd
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((FRACTION_BITS + 7) / 8) * 8-1:0] m_tdata   // fraction
);

    localparam int M_TDATA_W = ((FRACTION_BITS + 7) / 8) * 8;

    tlcg_cmd_t                cmd;
    logic [FRACTION_BITS-1:0] fraction;

    tlcg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    tlcg_dp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .seed_a   (s_tdata[0*SEED_W +: SEED_W]),
        .seed_b   (s_tdata[1*SEED_W +: SEED_W]),
        .seed_c   (s_tdata[2*SEED_W +: SEED_W]),
        .fraction (fraction)
    );

    assign m_tdata = M_TDATA_W'(fraction);

    // a draw keeps the input closed on the following cycle
    a_draw_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == CMD_DRAW_MAIN || s_tuser == CMD_DRAW_ALT))
        |=> !s_tready)
        else $error("input open right after draw item");

    // a load never produces a result
    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == CMD_LOAD_MAIN || s_tuser == CMD_LOAD_ALT))
        |=> !$rose(m_tvalid))
        else $error("result raised by load item");

    // a new result only appears while the block is busy with a draw
    a_result_from_draw: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result raised while idle");

endmodule
